/* src/oksrgb_pkg.sv */
// oksrgb_pkg: shared constants, types and the gamma table entry function
`timescale 1ns / 1ps
`default_nettype none

package oksrgb_pkg;

    // internal fixed point: Q.24 working values, Q.30 for the table search
    localparam int WF = 24;
    localparam int TF = 30;
    localparam int ONE_W = 1 << WF;
    localparam int HALF_W = 1 << (WF - 1);
    localparam int EPS_W = 1678;
    localparam int LIN_KNEE = 52526;
    localparam int LIN_MUL = 32946;
    localparam int LIN_HALF = 5 << WF;
    localparam int LMS_LIM = 16 << WF;

    // pipeline split
    localparam int ST_LMS = 5;
    localparam int ST_MIX = 2;
    localparam int ST_GAM = 4;
    localparam int N_STAGES = ST_LMS + ST_MIX + ST_GAM;

    // datapath widths
    localparam int AX_W = 28;
    localparam int P1_W = 46;
    localparam int X_W = 30;
    localparam int SQ_W = 34;
    localparam int CB_W = 62;
    localparam int LMS_W = 38;
    localparam int P2_W = 58;
    localparam int LIN_W = 44;
    localparam int G_W = 27;

    typedef logic signed [LMS_W-1:0] t_lms;
    typedef logic signed [LIN_W-1:0] t_lin;
    typedef logic signed [G_W-1:0] t_gent;

    // first matrix, a and b columns, Q.16
    localparam logic signed [17:0] M1 [3][2] = '{
        '{ 18'sd25974,  18'sd14143},
        '{-18'sd6918,  -18'sd4185 },
        '{-18'sd5864,  -18'sd84639}
    };

    // second matrix, Q.16
    localparam logic signed [19:0] M2 [3][3] = '{
        '{ 20'sd267173, -20'sd216774,  20'sd15137 },
        '{-20'sd83128,   20'sd171033, -20'sd22369 },
        '{-20'sd275,    -20'sd46099,   20'sd111910}
    };

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> TF;
    endfunction

    // power segment entry for Q.30 abscissa xq: bitwise search of y with y^12 <= xq^5
    function automatic t_gent gamma_entry(input logic [63:0] xq);
        logic [63:0] x2, x4, target, y, cand, c2, c4, c8, p12;
        logic signed [63:0] s30;
        x2 = mul_q30(xq, xq);
        x4 = mul_q30(x2, x2);
        target = mul_q30(x4, xq);
        y = 64'd0;
        for (int k = TF; k >= 0; k--) begin
            cand = y | (64'd1 << k);
            c2 = mul_q30(cand, cand);
            c4 = mul_q30(c2, c2);
            c8 = mul_q30(c4, c4);
            p12 = mul_q30(c8, c4);
            if (cand <= (64'd1 << TF) && p12 <= target) begin
                y = cand;
            end
        end
        s30 = $signed((y * 64'd1055 + 64'd500) / 64'd1000) - 64'sd59055800;
        return G_W'((s30 + 64'sd32) >>> (TF - WF));
    endfunction

endpackage

`default_nettype wire

/* src/oklab_to_srgb_pixel_convert.sv */
// oklab_to_srgb_pixel_convert: oklab pixel in, 8 bit srgb pixel and gamut flag out
//
// input channel: i_valid / o_stall with i_lightness, i_axis_a, i_axis_b in fixed
// point with FRAC_BITS fraction bits; a transaction completes when valid is high
// and stall is low
// output channel: o_valid / i_stall with o_red, o_green, o_blue and o_in_gamut
// one pixel per clock sustained while i_stall is low; 11 register stages:
// input matrix, lightness add and saturate, square, cube, lms rounding,
// output matrix products and sum, and a four stage gamma unit with an
// interpolated table of GAMMA_TABLE_DEPTH + 1 entries read at two addresses
// per channel
// stall from the receiver holds the result in the output register; empty stages
// upstream still fill, so o_stall rises only when every stage holds a pixel
// reset (synchronous, active low) clears all stage valid bits; the gamma table
// is constant and needs no fill after reset
`timescale 1ns / 1ps
`default_nettype none

module oklab_to_srgb_pixel_convert import oksrgb_pkg::*; #(
    parameter int FRAC_BITS = 15,
    parameter int GAMMA_TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_lightness,
    input  logic signed [15:0]  i_axis_a,
    input  logic signed [15:0]  i_axis_b,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic                o_in_gamut
);

    logic [N_STAGES-1:0]  r_valid;
    logic [N_STAGES:0]    w_en;
    t_lms                 w_lms [3];
    t_lin                 w_lin [3];
    logic [7:0]           w_byte [3];
    logic [2:0]           w_ok;

    // a stage moves when it is empty or the stage after it moves
    assign w_en[N_STAGES] = !i_stall;
    for (genvar k = 0; k < N_STAGES; k++) begin : g_en
        assign w_en[k] = !r_valid[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    oksrgb_lms #(
        .FRAC_BITS(FRAC_BITS)
    ) u_lms (
        .i_clk       (i_clk),
        .i_en        (w_en[ST_LMS-1:0]),
        .i_lightness (i_lightness),
        .i_axis_a    (i_axis_a),
        .i_axis_b    (i_axis_b),
        .o_lms       (w_lms)
    );

    oksrgb_mix u_mix (
        .i_clk (i_clk),
        .i_en  (w_en[ST_LMS+ST_MIX-1:ST_LMS]),
        .i_lms (w_lms),
        .o_lin (w_lin)
    );

    for (genvar c = 0; c < 3; c++) begin : g_chan
        oksrgb_gamma #(
            .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH)
        ) u_gamma (
            .i_clk  (i_clk),
            .i_en   (w_en[N_STAGES-1:ST_LMS+ST_MIX]),
            .i_lin  (w_lin[c]),
            .o_byte (w_byte[c]),
            .o_ok   (w_ok[c])
        );
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_valid[N_STAGES-1];
    assign o_red = w_byte[0];
    assign o_green = w_byte[1];
    assign o_blue = w_byte[2];
    assign o_in_gamut = &w_ok;

endmodule

`default_nettype wire

/* src/oksrgb_lms.sv */
// oksrgb_lms: input alignment, first matrix and cubing of the three lms terms
`timescale 1ns / 1ps
`default_nettype none

module oksrgb_lms import oksrgb_pkg::*; #(
    parameter int FRAC_BITS = 15
) (
    input  logic                    i_clk,
    input  logic [ST_LMS-1:0]       i_en,
    input  logic [15:0]             i_lightness,
    input  logic signed [15:0]      i_axis_a,
    input  logic signed [15:0]      i_axis_b,
    output t_lms                    o_lms [3]
);

    localparam int SHIFT = WF - FRAC_BITS;

    logic [AX_W-1:0]         n_lw, r_lw;
    logic signed [AX_W-1:0]  w_aw, w_bw;
    logic signed [P1_W-1:0]  n_p1 [3][2];
    logic signed [P1_W-1:0]  r_p1 [3][2];
    logic signed [P1_W:0]    w_s [3];
    logic signed [30:0]      w_t [3];
    logic signed [33:0]      w_x [3];
    logic signed [X_W-1:0]   n_x [3];
    logic signed [X_W-1:0]   r_x [3];
    logic signed [X_W-1:0]   r_x3 [3];
    logic signed [59:0]      w_xx [3];
    logic signed [SQ_W-1:0]  n_sq [3];
    logic signed [SQ_W-1:0]  r_sq [3];
    logic signed [CB_W-1:0]  n_cb [3];
    logic signed [CB_W-1:0]  r_cb [3];
    t_lms                    n_lms [3];
    t_lms                    r_lms [3];

    // align to q.24 and apply the a and b columns
    always_comb begin
        n_lw = AX_W'(i_lightness) << SHIFT;
        w_aw = AX_W'(i_axis_a) <<< SHIFT;
        w_bw = AX_W'(i_axis_b) <<< SHIFT;
        for (int k = 0; k < 3; k++) begin
            n_p1[k][0] = P1_W'(M1[k][0]) * P1_W'(w_aw);
            n_p1[k][1] = P1_W'(M1[k][1]) * P1_W'(w_bw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lw <= n_lw;
            r_p1 <= n_p1;
        end
    end

    // round, add lightness, saturate before cubing
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_s[k] = (P1_W+1)'(r_p1[k][0]) + (P1_W+1)'(r_p1[k][1]);
            w_t[k] = 31'((w_s[k] + (P1_W+1)'(32768)) >>> 16);
            w_x[k] = 34'(w_t[k]) + $signed({6'b0, r_lw});
            if (w_x[k] > 34'(LMS_LIM)) begin
                n_x[k] = X_W'(LMS_LIM);
            end else if (w_x[k] < -34'(LMS_LIM)) begin
                n_x[k] = -X_W'(LMS_LIM);
            end else begin
                n_x[k] = w_x[k][X_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x <= n_x;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_xx[k] = 60'(r_x[k]) * 60'(r_x[k]);
            n_sq[k] = SQ_W'((w_xx[k] + 60'(HALF_W)) >>> WF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sq <= n_sq;
            r_x3 <= r_x;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_cb[k] = CB_W'(64'(r_sq[k]) * 64'(r_x3[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_cb <= n_cb;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lms[k] = LMS_W'((r_cb[k] + CB_W'(HALF_W)) >>> WF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_lms <= n_lms;
        end
    end

    assign o_lms = r_lms;

endmodule

`default_nettype wire

/* src/oksrgb_mix.sv */
// oksrgb_mix: second matrix from lms terms to linear rgb in q.24
`timescale 1ns / 1ps
`default_nettype none

module oksrgb_mix import oksrgb_pkg::*; (
    input  logic                i_clk,
    input  logic [ST_MIX-1:0]   i_en,
    input  t_lms                i_lms [3],
    output t_lin                o_lin [3]
);

    logic signed [P2_W-1:0]  n_q [3][3];
    logic signed [P2_W-1:0]  r_q [3][3];
    logic signed [P2_W+1:0]  w_sum [3];
    t_lin                    n_lin [3];
    t_lin                    r_lin [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_q[k][j] = P2_W'(M2[k][j]) * P2_W'(i_lms[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q <= n_q;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = (P2_W+2)'(r_q[k][0]) + (P2_W+2)'(r_q[k][1]) + (P2_W+2)'(r_q[k][2]);
            n_lin[k] = LIN_W'((w_sum[k] + (P2_W+2)'(32768)) >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_lin <= n_lin;
        end
    end

    assign o_lin = r_lin;

endmodule

`default_nettype wire

/* src/oksrgb_gamma.sv */
// oksrgb_gamma: gamut check, clamp and srgb transfer curve for one channel
`timescale 1ns / 1ps
`default_nettype none

module oksrgb_gamma import oksrgb_pkg::*; #(
    parameter int GAMMA_TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic [ST_GAM-1:0]   i_en,
    input  t_lin                i_lin,
    output logic [7:0]          o_byte,
    output logic                o_ok
);

    localparam int C_W = WF + 1;
    localparam int IDX_W = $clog2(GAMMA_TABLE_DEPTH + 1);
    localparam int POS_W = WF + IDX_W;
    localparam int DF_W = G_W + 1;
    localparam int DP_W = DF_W + WF + 1;
    localparam int S_W = G_W + 2;
    localparam int V_W = 38;

    t_gent w_rom [GAMMA_TABLE_DEPTH+1];

    // power segment table, built at elaboration
    for (genvar g = 0; g <= GAMMA_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [63:0] XQ = (64'(g) << TF) / GAMMA_TABLE_DEPTH;
        localparam t_gent ENTRY = gamma_entry(XQ);
        assign w_rom[g] = ENTRY;
    end

    logic [C_W-1:0]          w_c;
    logic [31:0]             w_n;
    logic [POS_W-1:0]        w_pos;
    logic                    n_ok, n_knee;
    logic [IDX_W-1:0]        r_idx;
    logic [WF-1:0]           r_frac;
    logic                    r_knee, r_ok;
    logic [7:0]              r_lx;

    // gamut check, clamp to [0,1], split into table index and fraction
    always_comb begin
        n_ok = !(i_lin < -EPS_W || i_lin > ONE_W + EPS_W);
        if (i_lin < 0) begin
            w_c = '0;
        end else if (i_lin > ONE_W) begin
            w_c = C_W'(ONE_W);
        end else begin
            w_c = i_lin[C_W-1:0];
        end
        n_knee = w_c <= C_W'(LIN_KNEE);
        w_n = 32'(w_c[15:0]) * 32'(LIN_MUL) + 32'(LIN_HALF);
        w_pos = POS_W'(w_c) * POS_W'(GAMMA_TABLE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_idx <= w_pos[POS_W-1:WF];
            r_frac <= w_pos[WF-1:0];
            r_knee <= n_knee;
            r_ok <= n_ok;
            r_lx <= w_n[31:WF];
        end
    end

    logic [IDX_W-1:0]  w_idx1;
    logic [15:0]       w_lbp;
    t_gent             r_g0, r_g1;
    logic [WF-1:0]     r_frac2;
    logic              r_knee2, r_ok2;
    logic [7:0]        r_lb;

    // linear segment divide by ten as reciprocal multiply
    always_comb begin
        w_idx1 = (r_idx >= IDX_W'(GAMMA_TABLE_DEPTH)) ? r_idx : r_idx + IDX_W'(1);
        w_lbp = (16'(r_lx) * 16'd205) >> 11;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_g0 <= w_rom[r_idx];
            r_g1 <= w_rom[w_idx1];
            r_frac2 <= r_frac;
            r_knee2 <= r_knee;
            r_ok2 <= r_ok;
            r_lb <= w_lbp[7:0];
        end
    end

    logic signed [DF_W-1:0]  w_diff;
    logic signed [DP_W-1:0]  n_dp, r_dp;
    t_gent                   r_g0b;
    logic                    r_knee3, r_ok3;
    logic [7:0]              r_lb2;

    always_comb begin
        w_diff = DF_W'(r_g1) - DF_W'(r_g0);
        n_dp = DP_W'(w_diff) * DP_W'($signed({1'b0, r_frac2}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_dp <= n_dp;
            r_g0b <= r_g0;
            r_knee3 <= r_knee2;
            r_ok3 <= r_ok2;
            r_lb2 <= r_lb;
        end
    end

    logic signed [S_W-1:0]  w_s;
    logic [S_W-2:0]         w_sp;
    logic [V_W-1:0]         w_v;
    logic [7:0]             n_byte, r_byte;
    logic                   r_ok4;

    // interpolate, scale to 255 and saturate, or take the linear segment at the knee
    always_comb begin
        w_s = S_W'(r_g0b) + S_W'((r_dp + DP_W'(HALF_W)) >>> WF);
        w_sp = (w_s < 0) ? '0 : w_s[S_W-2:0];
        w_v = (V_W'(w_sp) * V_W'(255) + V_W'(HALF_W)) >> WF;
        if (r_knee3) begin
            n_byte = r_lb2;
        end else if (w_v > V_W'(255)) begin
            n_byte = 8'd255;
        end else begin
            n_byte = w_v[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_byte <= n_byte;
            r_ok4 <= r_ok3;
        end
    end

    assign o_byte = r_byte;
    assign o_ok = r_ok4;

endmodule

`default_nettype wire
